/* rtl/u8d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] ESC_BASE   = 21'h00DC00;
    localparam logic [7:0]      ASCII_LIM  = 8'h80;
    localparam logic [7:0]      LEAD2_MIN  = 8'hC0;
    localparam logic [7:0]      LEAD3_MIN  = 8'hE0;
    localparam logic [7:0]      LEAD4_MIN  = 8'hF0;
    localparam logic [7:0]      LEAD_LIM   = 8'hF8;
    localparam logic [1:0]      CONT_TAG   = 2'b10;
    localparam logic [7:0]      MASK_LEAD2 = 8'h1F;
    localparam logic [7:0]      MASK_LEAD3 = 8'h0F;
    localparam logic [7:0]      MASK_LEAD4 = 8'h07;
    localparam logic [7:0]      MASK_CONT  = 8'h3F;

    typedef struct packed {
        logic [1:0]      pending;
        logic [CP_W-1:0] partial;
        logic [2:0]      taken;
    } dec_state_t;

    typedef struct packed {
        logic [CP_W-1:0] char_val;
        logic            is_error;
        logic [2:0]      seq_bytes;
        logic            last;
    } dec_result_t;

    typedef struct packed {
        logic        has_result;
        logic        consume;
        dec_result_t result;
        dec_state_t  state;
    } dec_step_t;

endpackage
`default_nettype wire

/* rtl/u8d_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_step
// Combinational decode of one byte against the open sequence state.
// ----------------------------------------------------------------------------
module u8d_step import u8d_pkg::*; (
    input  wire logic [7:0] data_byte,
    input  wire dec_state_t state,
    output dec_step_t       step
);

    logic            is_cont;
    logic            fresh_emits;
    dec_result_t     fresh_res;
    dec_state_t      fresh_state;
    logic [CP_W-1:0] shifted;
    logic [CP_W-1:0] esc_value;

    assign is_cont   = (data_byte[7:6] == CONT_TAG);
    assign esc_value = ESC_BASE | CP_W'(data_byte);
    assign shifted   = {state.partial[CP_W-7:0], data_byte[5:0] & MASK_CONT[5:0]};

    always_comb begin
        fresh_emits = 1'b1;
        fresh_res   = '{char_val: esc_value, is_error: 1'b1, seq_bytes: 3'd1, last: 1'b1};
        fresh_state = '0;
        priority if (data_byte < ASCII_LIM) begin
            fresh_res.char_val = CP_W'(data_byte);
            fresh_res.is_error = 1'b0;
        end else if (data_byte < LEAD2_MIN) begin
            fresh_emits = 1'b1;
        end else if (data_byte < LEAD3_MIN) begin
            fresh_emits = 1'b0;
            fresh_state = '{pending: 2'd1, partial: CP_W'(data_byte & MASK_LEAD2), taken: 3'd1};
        end else if (data_byte < LEAD4_MIN) begin
            fresh_emits = 1'b0;
            fresh_state = '{pending: 2'd2, partial: CP_W'(data_byte & MASK_LEAD3), taken: 3'd1};
        end else if (data_byte < LEAD_LIM) begin
            fresh_emits = 1'b0;
            fresh_state = '{pending: 2'd3, partial: CP_W'(data_byte & MASK_LEAD4), taken: 3'd1};
        end else begin
            fresh_emits = 1'b1;
        end
    end

    always_comb begin
        step = '0;
        priority if (state.pending == 2'd0) begin
            step.has_result = fresh_emits;
            step.consume    = 1'b1;
            step.result     = fresh_res;
            step.state      = fresh_state;
        end else if (is_cont) begin
            step.consume = 1'b1;
            if (state.pending == 2'd1) begin
                step.has_result = 1'b1;
                step.result     = '{char_val: shifted, is_error: 1'b0,
                                    seq_bytes: state.taken + 3'd1, last: 1'b1};
                step.state      = '0;
            end else begin
                step.has_result = 1'b0;
                step.state      = '{pending: state.pending - 2'd1, partial: shifted,
                                    taken: state.taken + 3'd1};
            end
        end else begin
            // The broken sequence is escaped first. When the restart byte also
            // yields a result, the byte is held and decoded again.
            step.has_result = 1'b1;
            step.result     = '{char_val: esc_value, is_error: 1'b1,
                                seq_bytes: state.taken, last: !fresh_emits};
            step.consume    = !fresh_emits;
            step.state      = fresh_emits ? dec_state_t'('0) : fresh_state;
        end
    end

endmodule
`default_nettype wire

/* rtl/utf8_stream_decoder_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Byte-serial UTF-8 decoder producing code points and escaped error values.
// A byte is captured in the input register at its transfer, and its result is
// loaded into the result register when the decode stage is enabled. One byte per
// cycle while the output is not stalled; a broken sequence whose restart byte
// also gives a result keeps that byte to decode it again. Synchronous active-low
// reset empties both registers and closes any open sequence.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core import u8d_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_data_byte,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [CP_W-1:0]      m_char_val,
    output logic                 m_is_error,
    output logic [2:0]           m_seq_bytes,
    output logic                 m_last
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    dec_result_t out_reg;
    dec_state_t  state_reg;
    dec_step_t   step;
    logic        step_en;
    logic        in_load;

    u8d_step u_step (
        .data_byte (in_byte_reg),
        .state     (state_reg),
        .step      (step)
    );

    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || (step_en && step.consume);
    assign in_load = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (step_en && step.consume) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step_en) begin
            out_valid_next = step.has_result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_en) begin
                state_reg <= step.state;
            end
        end
        if (in_load) begin
            in_byte_reg <= s_data_byte;
        end
        if (step_en && step.has_result) begin
            out_reg <= step.result;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_char_val  = out_reg.char_val;
    assign m_is_error  = out_reg.is_error;
    assign m_seq_bytes = out_reg.seq_bytes;
    assign m_last      = out_reg.last;

endmodule
`default_nettype wire

/* dv/utf8_stream_decoder_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core_tb
// Self-checking testbench for the byte-serial UTF-8 decoder. A directed set of
// byte sequences is followed by random well-formed, broken and noise streams.
// Every accepted byte is decoded by a local predictor, and each result
// transfer is compared field by field with the oldest predicted code point.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core_tb import u8d_pkg::*;;

    localparam int unsigned RANDOM_BYTES = 1550;
    localparam int unsigned DIRECTED_N   = 24;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int unsigned TAIL_CYCLES  = 10;

    // Lone bytes at the range ends, 2/3/4-byte sequences up to the largest
    // value, then sequences broken by an ASCII byte, an invalid lead and a
    // new lead.
    localparam logic [DIRECTED_N*8-1:0] DIRECTED_BYTES = {
        8'h00, 8'h7F, 8'h80, 8'hFF,
        8'hC2, 8'hA9,
        8'hE2, 8'h82, 8'hAC,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,
        8'hC3, 8'h41,
        8'hE0, 8'hA0, 8'hF8,
        8'hF0, 8'h9F, 8'hC3, 8'hA9,
        8'hC0, 8'h80
    };

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [7:0]          s_data_byte  = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [CP_W-1:0]     m_char_val;
    logic                m_is_error;
    logic [2:0]          m_seq_bytes;
    logic                m_last;

    logic [7:0]          stream_bytes[$];
    dec_result_t         pred_q[$];
    dec_state_t          dec_st = '0;

    int unsigned         in_gap       = 0;
    int unsigned         in_burst     = 0;
    int unsigned         out_stall    = 0;
    int unsigned         out_burst    = 0;
    int unsigned         bytes_sent   = 0;
    int unsigned         results_seen = 0;
    int unsigned         escapes_seen = 0;
    int unsigned         err_count    = 0;

    utf8_stream_decoder_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_val   (m_char_val),
        .m_is_error   (m_is_error),
        .m_seq_bytes  (m_seq_bytes),
        .m_last       (m_last)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned pick_gap(input int unsigned burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst > 0 || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 40);
        end
    endfunction

    function automatic int unsigned next_burst(input int unsigned burst);
        if (burst > 0) begin
            return burst - 1;
        end else if ($urandom_range(0, 99) < 3) begin
            return $urandom_range(20, 80);
        end else begin
            return 0;
        end
    endfunction

    function automatic dec_result_t make_result(input logic [CP_W-1:0] cp, input logic err,
                                                input logic [2:0] nb, input logic lst);
        dec_result_t r;
        r.char_val  = cp;
        r.is_error  = err;
        r.seq_bytes = nb;
        r.last      = lst;
        return r;
    endfunction

    task automatic start_byte(input logic [7:0] b);
        if (b < ASCII_LIM) begin
            pred_q.push_back(make_result(CP_W'(b), 1'b0, 3'd1, 1'b1));
        end else if (b < LEAD2_MIN || b >= LEAD_LIM) begin
            pred_q.push_back(make_result(ESC_BASE | CP_W'(b), 1'b1, 3'd1, 1'b1));
        end else begin
            if (b < LEAD3_MIN) begin
                dec_st.pending = 2'd1;
                dec_st.partial = CP_W'(b & MASK_LEAD2);
            end else if (b < LEAD4_MIN) begin
                dec_st.pending = 2'd2;
                dec_st.partial = CP_W'(b & MASK_LEAD3);
            end else begin
                dec_st.pending = 2'd3;
                dec_st.partial = CP_W'(b & MASK_LEAD4);
            end
            dec_st.taken = 3'd1;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic restart_opens;
        restart_opens = (b >= LEAD2_MIN) && (b < LEAD_LIM);
        if (dec_st.pending == 2'd0) begin
            start_byte(b);
        end else if (b[7:6] == CONT_TAG) begin
            dec_st.partial = {dec_st.partial[CP_W-7:0], b[5:0] & MASK_CONT[5:0]};
            dec_st.taken   = dec_st.taken + 3'd1;
            dec_st.pending = dec_st.pending - 2'd1;
            if (dec_st.pending == 2'd0) begin
                pred_q.push_back(make_result(dec_st.partial, 1'b0, dec_st.taken, 1'b1));
                dec_st = '0;
            end
        end else begin
            pred_q.push_back(make_result(ESC_BASE | CP_W'(b), 1'b1, dec_st.taken,
                                         restart_opens));
            dec_st = '0;
            start_byte(b);
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte);
                bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (in_gap > 0) begin
                    s_valid <= 1'b0;
                    in_gap--;
                end else if (stream_bytes.size() > 0) begin
                    s_valid     <= 1'b1;
                    s_data_byte <= stream_bytes.pop_front();
                    in_burst = next_burst(in_burst);
                    in_gap   = pick_gap(in_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        dec_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_is_error) begin
                    escapes_seen++;
                end
                if (pred_q.size() == 0) begin
                    report_mismatch("unexpected transfer, char_val", m_char_val, 0);
                end else begin
                    want = pred_q.pop_front();
                    if (m_char_val !== want.char_val) begin
                        report_mismatch("char_val", m_char_val, want.char_val);
                    end
                    if (m_is_error !== want.is_error) begin
                        report_mismatch("is_error", m_is_error, want.is_error);
                    end
                    if (m_seq_bytes !== want.seq_bytes) begin
                        report_mismatch("seq_bytes", m_seq_bytes, want.seq_bytes);
                    end
                    if (m_last !== want.last) begin
                        report_mismatch("last", m_last, want.last);
                    end
                end
            end
            if (out_stall > 0) begin
                m_ready <= 1'b0;
                out_stall--;
            end else begin
                m_ready <= 1'b1;
                out_burst = next_burst(out_burst);
                out_stall = pick_gap(out_burst);
            end
        end
    end

    initial begin
        int unsigned pick;
        int unsigned len;
        int unsigned conts;
        int unsigned kind;
        int unsigned drain;
        logic        broken;

        for (int i = 0; i < DIRECTED_N; i++) begin
            stream_bytes.push_back(DIRECTED_BYTES[(DIRECTED_N-1-i)*8 +: 8]);
        end
        while (stream_bytes.size() < DIRECTED_N + RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                stream_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 30) begin
                stream_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
            end else begin
                len = $urandom_range(2, 4);
                case (len)
                    2: stream_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                    3: stream_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    default: stream_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                endcase
                broken = (pick >= 88);
                conts  = broken ? $urandom_range(0, len - 2) : len - 1;
                for (int j = 0; j < conts; j++) begin
                    stream_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                if (broken) begin
                    kind = $urandom_range(0, 2);
                    if (kind == 0) begin
                        stream_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
                    end else if (kind == 1) begin
                        stream_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
                    end else begin
                        stream_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
                    end
                end
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (stream_bytes.size() > 0 || s_valid) begin
            @(posedge aclk);
        end
        drain = 0;
        while (pred_q.size() > 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pred_q.size() > 0) begin
            report_mismatch("results never transferred, count", 0, pred_q.size());
        end

        $display("Decoded %0d input bytes into %0d results, %0d of them escaped errors.",
                 bytes_sent, results_seen, escapes_seen);
        $display("Covered ASCII, multi-byte, stray, invalid and broken input; %0d mismatches.",
                 err_count);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout: the stream did not finish in time.");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
